// ===== design/stl_pkg.sv =====
`default_nettype none
package stl_pkg;

   typedef struct packed {
      logic [2:0]         mode;
      logic [31:0]        seg_index;
      logic signed [63:0] time_req;
      logic [31:0]        duration;
      logic               strict;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        found_index;
      logic signed [63:0] found_time;
      logic [31:0]        found_duration;
      logic [31:0]        run_offset;
   } rsp_type;

   localparam logic [2:0] MODE_ADD     = 3'd0;
   localparam logic [2:0] MODE_UPDATE  = 3'd1;
   localparam logic [2:0] MODE_TRIM    = 3'd2;
   localparam logic [2:0] MODE_FLOOR   = 3'd3;
   localparam logic [2:0] MODE_CLOSEST = 3'd4;
   localparam logic [2:0] MODE_INDEX   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_REJECT   = 2'd3;

   typedef struct packed {
      logic [31:0] dur;
      logic [31:0] rep;
      logic [31:0] first;
      logic [63:0] start;
      logic [31:0] period;
   } run_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD, S_WAIT, S_EVAL, S_RD2, S_WAIT2, S_EVAL2,
      S_DIV, S_MUL, S_EMIT, S_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
   } div_stat_type;

endpackage
`default_nettype wire

// ===== design/stl_divider.sv =====
`default_nettype none
module stl_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire stl_pkg::div_cmd_type cmd,
   output stl_pkg::div_stat_type     stat
);
   import stl_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   // restoring radix-2 divide, one quotient bit a cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], quo_ff[63]};
      trial   = shifted - {1'b0, dvs_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && !cmd.start |=> !done_ff || $past(busy_ff))
      else $error("spurious done");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 7'd0) else $error("busy with zero count");

endmodule
`default_nettype wire

// ===== design/segment_timeline_run_table_top.sv =====
`default_nettype none
// Run-length segment timeline kept as a ring of up to RUN_DEPTH runs in one
// run memory with separate read and write ports. One request is handled at a
// time and req_ready is low while it is worked on and while its response
// waits. An add, an update or an unused mode answers after at most one read
// of the tail run (an update may also read the run before the tail). Trim
// reads and drops runs at the head one at a time. Lookups scan the runs one
// memory read at a time after a decode state; a time lookup then waits on a
// one-bit-a-cycle divider. A multiply state, an output state and the response
// state follow. A response waits in its register until rsp_ready, and the
// next request can be taken the cycle after. No clearing pass is needed after
// reset.
module segment_timeline_run_table_top #(
   parameter int RUN_DEPTH = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire stl_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output stl_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [31:0]      csr_wdata
);
   import stl_pkg::*;

   localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
   localparam int CW = $clog2(RUN_DEPTH + 1);

   run_type mem [RUN_DEPTH];
   run_type rd_ff;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   run_type       wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [31:0] pend_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] total_ff, total_in;
   logic [31:0] tail_idx_ff, tail_idx_in;
   logic [63:0] tail_end_ff, tail_end_in;
   logic [CW-1:0] pos_ff, pos_in;
   run_type   cur_ff, cur_in;
   run_type   prv_ff, prv_in;
   logic [AW-1:0] cur_slot_ff, cur_slot_in;
   logic          have_next_ff, have_next_in;
   run_type       next_ff, next_in;
   logic [31:0] off_ff, off_in;
   logic [63:0] prod_ff, prod_in;
   div_cmd_type dcmd;
   div_stat_type dstat;

   stl_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .stat(dstat));

   function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] head,
                                             input logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, pos};
      if (sum >= (CW + 1)'(RUN_DEPTH)) sum = sum - (CW + 1)'(RUN_DEPTH);
      return sum[AW-1:0];
   endfunction

   logic [63:0] span;
   logic [63:0] diff;
   logic [32:0] last_idx;
   logic        s_le;

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      cur_ff      <= cur_in;
      prv_ff      <= prv_in;
      cur_slot_ff <= cur_slot_in;
      next_ff     <= next_in;
      off_ff      <= off_in;
      prod_ff     <= prod_in;
      if (reset) begin
         pend_ff      <= '0;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         total_ff     <= '0;
         tail_idx_ff  <= '0;
         tail_end_ff  <= '0;
         pos_ff       <= '0;
         have_next_ff <= 1'b0;
      end else begin
         if (csr_write) pend_ff <= csr_wdata;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         tail_idx_ff  <= tail_idx_in;
         tail_end_ff  <= tail_end_in;
         pos_ff       <= pos_in;
         have_next_ff <= have_next_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      tail_idx_in  = tail_idx_ff;
      tail_end_in  = tail_end_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      prv_in       = prv_ff;
      cur_slot_in  = cur_slot_ff;
      have_next_in = have_next_ff;
      next_in      = next_ff;
      off_in       = off_ff;
      prod_in      = prod_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = cur_ff;
      dcmd         = '0;
      req_ready    = 1'b0;
      span         = 64'(cur_ff.rep) * 64'(cur_ff.dur);
      diff         = req_ff.time_req - cur_ff.start;
      last_idx     = {1'b0, cur_ff.first} + {1'b0, cur_ff.rep} - 33'd1;
      s_le         = $signed(cur_ff.start) <= $signed(req_ff.time_req);
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               req_in   = req_data;
               rsp_in   = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (req_ff.mode) inside
               MODE_ADD, MODE_UPDATE: begin
                  if (total_ff == '0) begin
                     if (req_ff.mode == MODE_UPDATE) begin
                        rsp_in.status = ST_REJECT;
                        state_in = S_DONE;
                     end else begin
                        cur_in = '0;
                        cur_in.period = 32'hFFFF_FFFF; // becomes 0 on new period
                        state_in = S_EVAL;
                     end
                  end else begin
                     rd_en = 1'b1;
                     rd_addr = slot_at(head_ff, total_ff - CW'(1));
                     cur_slot_in = rd_addr;
                     state_in = S_WAIT;
                  end
               end
               MODE_TRIM: begin
                  pos_in = CW'(1);
                  state_in = S_RD;
               end
               MODE_FLOOR, MODE_CLOSEST: begin
                  pos_in = total_ff;
                  state_in = S_RD;
               end
               MODE_INDEX: begin
                  pos_in = '0;
                  have_next_in = 1'b0;
                  state_in = S_RD;
               end
               default: begin
                  rsp_in.status = ST_NOTFOUND;
                  state_in = S_DONE;
               end
            endcase
         end
         S_RD: begin
            // trim reads run 1, floor scans down, index scans up
            if (req_ff.mode == MODE_TRIM) begin
               if (total_ff < CW'(2)) state_in = S_DONE;
               else begin
                  rd_en = 1'b1;
                  rd_addr = slot_at(head_ff, CW'(1));
                  state_in = S_WAIT;
               end
            end else if (req_ff.mode == MODE_INDEX) begin
               if (pos_ff == total_ff) begin
                  if (req_ff.strict || !have_next_ff) begin
                     rsp_in.status = ST_NOTFOUND;
                     state_in = S_DONE;
                  end else begin
                     cur_in = next_ff;
                     off_in = '0;
                     state_in = S_MUL;
                  end
               end else begin
                  rd_en = 1'b1;
                  rd_addr = slot_at(head_ff, pos_ff);
                  state_in = S_WAIT;
               end
            end else begin
               if (pos_ff == '0) begin
                  rsp_in.status = ST_NOTFOUND;
                  state_in = S_DONE;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = slot_at(head_ff, pos_ff - CW'(1));
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            cur_in = rd_ff;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (req_ff.mode)
               MODE_ADD: begin
                  if (total_ff != '0 && req_ff.time_req == tail_end_ff &&
                      req_ff.seg_index == tail_idx_ff + 32'd1 &&
                      cur_ff.dur == req_ff.duration && cur_ff.rep != 32'hFFFF_FFFF) begin
                     wr_en = 1'b1;
                     wr_addr = cur_slot_ff;
                     wr_data = cur_ff;
                     wr_data.rep = cur_ff.rep + 32'd1;
                     tail_idx_in = req_ff.seg_index;
                     tail_end_in = req_ff.time_req + 64'(req_ff.duration);
                     state_in = S_DONE;
                  end else if (total_ff >= CW'(RUN_DEPTH)) begin
                     rsp_in.status = ST_FULL;
                     state_in = S_DONE;
                  end else begin
                     wr_en = 1'b1;
                     wr_addr = slot_at(head_ff, total_ff);
                     wr_data.dur = req_ff.duration;
                     wr_data.rep = 32'd1;
                     wr_data.first = req_ff.seg_index;
                     wr_data.start = req_ff.time_req;
                     if (total_ff != '0 && req_ff.time_req == tail_end_ff &&
                         req_ff.seg_index == tail_idx_ff + 32'd1)
                        wr_data.period = cur_ff.period;
                     else
                        wr_data.period = cur_ff.period + 32'd1;
                     total_in = total_ff + CW'(1);
                     tail_idx_in = req_ff.seg_index;
                     tail_end_in = req_ff.time_req + 64'(req_ff.duration);
                     state_in = S_DONE;
                  end
               end
               MODE_UPDATE: begin
                  if (cur_ff.rep != 32'd1 || cur_ff.dur != pend_ff) begin
                     rsp_in.status = ST_REJECT;
                     state_in = S_DONE;
                  end else begin
                     tail_end_in = tail_end_ff + 64'(req_ff.duration);
                     if (total_ff >= CW'(2)) begin
                        prv_in = cur_ff;
                        rd_en = 1'b1;
                        rd_addr = slot_at(head_ff, total_ff - CW'(2));
                        state_in = S_WAIT2;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = cur_slot_ff;
                        wr_data.dur = req_ff.duration;
                        state_in = S_DONE;
                     end
                  end
               end
               MODE_TRIM: begin
                  if (req_ff.seg_index > cur_ff.first) begin
                     head_in = slot_at(head_ff, CW'(1));
                     total_in = total_ff - CW'(1);
                     state_in = S_RD;
                  end else state_in = S_DONE;
               end
               MODE_INDEX: begin
                  if (req_ff.seg_index >= cur_ff.first &&
                      {1'b0, req_ff.seg_index} <= last_idx) begin
                     off_in = req_ff.seg_index - cur_ff.first;
                     state_in = S_MUL;
                  end else begin
                     if (!have_next_ff && cur_ff.first > req_ff.seg_index) begin
                        have_next_in = 1'b1;
                        next_in = cur_ff;
                     end
                     pos_in = pos_ff + CW'(1);
                     state_in = S_RD;
                  end
               end
               default: begin
                  // time lookups
                  if (s_le) begin
                     if (diff >= span) begin
                        rsp_in.status = ST_NOTFOUND;
                        state_in = S_DONE;
                     end else begin
                        dcmd.start = 1'b1;
                        dcmd.dividend = (req_ff.mode == MODE_CLOSEST) ?
                           diff + 64'(cur_ff.dur >> 1) : diff;
                        dcmd.divisor = cur_ff.dur;
                        state_in = S_DIV;
                     end
                  end else begin
                     pos_in = pos_ff - CW'(1);
                     state_in = S_RD;
                  end
               end
            endcase
         end
         S_WAIT2: state_in = S_EVAL2;
         S_EVAL2: begin
            // rd_ff holds the run before the tail
            wr_en = 1'b1;
            if (rd_ff.period == prv_ff.period && rd_ff.dur == req_ff.duration &&
                rd_ff.rep != 32'hFFFF_FFFF) begin
               wr_addr = slot_at(head_ff, total_ff - CW'(2));
               wr_data = rd_ff;
               wr_data.rep = rd_ff.rep + 32'd1;
               total_in = total_ff - CW'(1);
            end else begin
               wr_addr = cur_slot_ff;
               wr_data = prv_ff;
               wr_data.dur = req_ff.duration;
            end
            state_in = S_DONE;
         end
         S_DIV: begin
            if (dstat.done) begin
               off_in = dstat.quotient[31:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = 64'(off_ff) * 64'(cur_ff.dur);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_in.status = ST_OK;
            rsp_in.found_index = cur_ff.first + off_ff;
            rsp_in.found_time = cur_ff.start + prod_ff;
            rsp_in.found_duration = cur_ff.dur;
            rsp_in.run_offset = off_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(RUN_DEPTH)) else $error("run count overflow");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_DECODE) else $error("request lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response dropped");
   a_no_write_lookup: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> req_ff.mode == MODE_ADD || req_ff.mode == MODE_UPDATE)
      else $error("write on lookup");

endmodule
`default_nettype wire

// ===== verif/tb_segment_timeline_run_table_top.sv =====
`default_nettype none
module tb_segment_timeline_run_table_top;
   timeunit 1ns;
   timeprecision 1ps;
   import stl_pkg::*;

   localparam int DEPTH = 256;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [31:0] csr_wdata = '0;

   segment_timeline_run_table_top #(.RUN_DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // timeline shadow
   logic [31:0] tl_dur[DEPTH];
   logic [31:0] tl_rep[DEPTH];
   logic [31:0] tl_first[DEPTH];
   logic [63:0] tl_start[DEPTH];
   logic [31:0] tl_period[DEPTH];
   int unsigned tl_head = 0;
   int unsigned tl_count = 0;
   logic [31:0] tl_last_idx = '0;
   logic [63:0] tl_end_time = '0;
   logic [31:0] pend_value = '0;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int unsigned mismatches = 0;
   bit no_gaps = 1'b0;
   bit hold_req = 1'b0;
   int unsigned hold_left = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;

   // request generator's view of the tail
   logic [31:0] gen_idx = '0;
   logic [63:0] gen_time = '0;
   logic [31:0] gen_dur = 32'd10;

   function automatic int unsigned slot(int unsigned pos);
      return (tl_head + pos) % DEPTH;
   endfunction

   function automatic rsp_type segment_at(int unsigned s, logic [31:0] off);
      rsp_type r;
      r = '0;
      r.found_index = tl_first[s] + off;
      r.found_time = tl_start[s] + {32'd0, off} * {32'd0, tl_dur[s]};
      r.found_duration = tl_dur[s];
      r.run_offset = off;
      return r;
   endfunction

   function automatic rsp_type predict_timeline(req_type q);
      rsp_type r;
      int unsigned s, p, i, next_s;
      logic [31:0] period;
      logic [63:0] diff, span, first, last;
      bit have_next;
      r = '0;
      case (q.mode) inside
         MODE_ADD: begin
            period = '0;
            if (tl_count > 0) begin
               s = slot(tl_count - 1);
               if (q.time_req == tl_end_time && q.seg_index == tl_last_idx + 32'd1) begin
                  if (tl_dur[s] == q.duration && tl_rep[s] != MAX32) begin
                     tl_rep[s]++;
                     tl_last_idx = q.seg_index;
                     tl_end_time = q.time_req + {32'd0, q.duration};
                     return r;
                  end
                  period = tl_period[s];
               end else begin
                  period = tl_period[s] + 32'd1;
               end
            end
            if (tl_count >= DEPTH) begin
               r.status = ST_FULL;
               return r;
            end
            s = slot(tl_count);
            tl_dur[s] = q.duration;
            tl_rep[s] = 32'd1;
            tl_first[s] = q.seg_index;
            tl_start[s] = q.time_req;
            tl_period[s] = period;
            tl_count++;
            tl_last_idx = q.seg_index;
            tl_end_time = q.time_req + {32'd0, q.duration};
         end
         MODE_UPDATE: begin
            if (tl_count == 0) begin
               r.status = ST_REJECT;
               return r;
            end
            s = slot(tl_count - 1);
            if (tl_rep[s] != 32'd1 || tl_dur[s] != pend_value) begin
               r.status = ST_REJECT;
               return r;
            end
            tl_end_time += {32'd0, q.duration};
            if (tl_count >= 2) begin
               p = slot(tl_count - 2);
               if (tl_period[p] == tl_period[s] && tl_dur[p] == q.duration
                   && tl_rep[p] != MAX32) begin
                  tl_rep[p]++;
                  tl_count--;
                  return r;
               end
            end
            tl_dur[s] = q.duration;
         end
         MODE_TRIM: begin
            while (tl_count >= 2 && q.seg_index > tl_first[slot(1)]) begin
               tl_head = (tl_head + 1) % DEPTH;
               tl_count--;
            end
         end
         MODE_FLOOR, MODE_CLOSEST: begin
            for (i = tl_count; i > 0; i--)
               if ($signed(tl_start[slot(i - 1)]) <= $signed(q.time_req)) break;
            if (i == 0) begin
               r.status = ST_NOTFOUND;
               return r;
            end
            s = slot(i - 1);
            diff = q.time_req - tl_start[s];
            span = {32'd0, tl_rep[s]} * {32'd0, tl_dur[s]};
            if (diff >= span) begin
               r.status = ST_NOTFOUND;
               return r;
            end
            if (q.mode == MODE_CLOSEST) diff += {32'd0, tl_dur[s] / 32'd2};
            r = segment_at(s, 32'(diff / {32'd0, tl_dur[s]}));
         end
         MODE_INDEX: begin
            have_next = 1'b0;
            next_s = 0;
            for (i = 0; i < tl_count; i++) begin
               s = slot(i);
               first = {32'd0, tl_first[s]};
               last = first + {32'd0, tl_rep[s]} - 64'd1;
               if ({32'd0, q.seg_index} >= first && {32'd0, q.seg_index} <= last)
                  return segment_at(s, q.seg_index - tl_first[s]);
               if (!have_next && first > {32'd0, q.seg_index}) begin
                  have_next = 1'b1;
                  next_s = s;
               end
            end
            if (q.strict || !have_next) r.status = ST_NOTFOUND;
            else r = segment_at(next_s, 32'd0);
         end
         default: r.status = ST_NOTFOUND;
      endcase
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(predict_timeline(req_data));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            recv_gap = pick_gap();
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.status !== e.status || rsp_data.found_index !== e.found_index
                   || rsp_data.found_time !== e.found_time
                   || rsp_data.found_duration !== e.found_duration
                   || rsp_data.run_offset !== e.run_offset) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected st=%0d idx=%0d t=%0d dur=%0d off=%0d",
                        e.status, e.found_index, e.found_time, e.found_duration,
                        e.run_offset);
                     $display("          got st=%0d idx=%0d t=%0d dur=%0d off=%0d",
                        rsp_data.status, rsp_data.found_index, rsp_data.found_time,
                        rsp_data.found_duration, rsp_data.run_offset);
                  end
               end
            end
         end
         if (hold_req) begin
            hold_left = 400;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_req(logic [2:0] m, logic [31:0] idx, logic [63:0] t,
                           logic [31:0] d, logic st);
      req_type q;
      q.mode = m;
      q.seg_index = idx;
      q.time_req = t;
      q.duration = d;
      q.strict = st;
      pending_reqs.push_back(q);
      if (m == MODE_ADD) begin
         gen_idx = idx + 32'd1;
         gen_time = t + {32'd0, d};
      end else if (m == MODE_UPDATE) begin
         gen_time += {32'd0, d};
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_pending(logic [31:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      pend_value = v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [31:0] pick_dur();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return gen_dur;
      if (roll < 7) return pend_value;
      gen_dur = $urandom_range(1, 120);
      return gen_dur;
   endfunction

   task automatic random_phase(int unsigned n);
      int unsigned k, roll;
      logic [31:0] d;
      for (k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            push_req(MODE_ADD, gen_idx, gen_time, pick_dur(), 1'b0);
         end else if (roll < 48) begin
            push_req(MODE_ADD, gen_idx + $urandom_range(0, 4),
                     gen_time + $urandom_range(1, 300), pick_dur(), 1'b0);
         end else if (roll < 56) begin
            // pending segment then its real length
            push_req(MODE_ADD, gen_idx, gen_time, pend_value, 1'b0);
            d = ($urandom_range(0, 1) != 0) ? gen_dur : pick_dur();
            push_req(MODE_UPDATE, 32'd0, 64'd0, d, 1'b0);
            k++;
         end else if (roll < 60) begin
            push_req(MODE_UPDATE, $urandom, {$urandom, $urandom}, pick_dur(),
                     1'($urandom));
         end else if (roll < 65) begin
            push_req(MODE_TRIM, gen_idx - $urandom_range(0, 40), 64'd0, 32'd0, 1'b0);
         end else if (roll < 90) begin
            d = $urandom_range(0, 2);
            push_req(d == 0 ? MODE_FLOOR : d == 1 ? MODE_CLOSEST : MODE_INDEX,
                     gen_idx - $urandom_range(0, 60),
                     gen_time - $urandom_range(0, 3000), 32'd0, 1'($urandom));
         end else begin
            push_req(3'($urandom), $urandom, {$urandom, $urandom}, $urandom,
                     1'($urandom));
         end
      end
   endtask

   initial begin
      int unsigned k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table, unused modes
      push_req(MODE_FLOOR, 32'd0, 64'd0, 32'd0, 1'b0);
      push_req(MODE_CLOSEST, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 1'b0);
      push_req(MODE_INDEX, 32'd0, 64'd0, 32'd0, 1'b1);
      push_req(MODE_UPDATE, 32'd0, 64'd0, 32'd5, 1'b0);
      push_req(MODE_TRIM, MAX32, 64'd0, 32'd0, 1'b0);
      push_req(3'd6, MAX32, 64'hFFFF_FFFF_FFFF_FFFF, MAX32, 1'b1);
      push_req(3'd7, 32'd0, 64'd0, 32'd0, 1'b0);
      // extremes and wrap of index and end time
      push_req(MODE_ADD, MAX32, 64'h8000_0000_0000_0000, MAX32, 1'b0);
      push_req(MODE_ADD, 32'd0, 64'h8000_0000_FFFF_FFFF, MAX32, 1'b0);
      push_req(MODE_FLOOR, 32'd0, 64'h8000_0001_0000_0005, 32'd0, 1'b0);
      push_req(MODE_CLOSEST, 32'd0, 64'h8000_0001_7FFF_FFFF, 32'd0, 1'b0);
      push_req(MODE_FLOOR, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 1'b0);
      push_req(MODE_ADD, 32'd1, 64'h7FFF_FFFF_FFFF_FFF0, 32'h20, 1'b0);
      push_req(MODE_INDEX, MAX32, 64'd0, 32'd0, 1'b0);
      // gap in index: strict and loose
      push_req(MODE_ADD, 32'd10, 64'd100, 32'd0, 1'b0);
      push_req(MODE_UPDATE, 32'd0, 64'd0, 32'd7, 1'b0);
      push_req(MODE_ADD, 32'd11, 64'd107, 32'd7, 1'b0);
      push_req(MODE_INDEX, 32'd5, 64'd0, 32'd0, 1'b1);
      push_req(MODE_INDEX, 32'd5, 64'd0, 32'd0, 1'b0);
      push_req(MODE_INDEX, 32'd11, 64'd0, 32'd0, 1'b1);
      push_req(MODE_CLOSEST, 32'd0, 64'd104, 32'd0, 1'b0);
      push_req(MODE_FLOOR, 32'd0, 64'd120, 32'd0, 1'b0);
      push_req(MODE_FLOOR, 32'd0, 64'd99, 32'd0, 1'b0);
      push_req(MODE_TRIM, 32'd11, 64'd0, 32'd0, 1'b0);
      wait_idle();

      write_pending(MAX32);
      random_phase(420);
      // sender pauses until everything is back
      wait_idle();

      // fill the ring until it reports full, with the receiver held off
      write_pending($urandom);
      gen_dur = 32'd3;
      hold_req = 1'b1;
      for (k = 0; k < DEPTH + 6; k++)
         push_req(MODE_ADD, gen_idx + 1, gen_time + 1, 32'd3, 1'b0);
      push_req(MODE_FLOOR, 32'd0, gen_time - 2, 32'd0, 1'b0);
      push_req(MODE_INDEX, gen_idx - 1, 64'd0, 32'd0, 1'b0);
      push_req(MODE_TRIM, MAX32, 64'd0, 32'd0, 1'b0);
      wait_idle();

      write_pending(32'd0);
      no_gaps = 1'b1;
      random_phase(150);
      wait_idle();
      no_gaps = 1'b0;
      random_phase(300);
      wait_idle();

      write_pending($urandom_range(1, 120));
      random_phase(240);
      wait_idle();

      if (mismatches == 0) $display("** segment_timeline_run_table_top: PASSED **");
      else $display("** segment_timeline_run_table_top: FAILED **");
      $finish;
   end

   initial begin
      #100ms;
      $display("** segment_timeline_run_table_top: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
